// ----- rtl/mos6502_operand_mode_parser_assert.svh -----
// Assertion macros for the 6502 operand mode parser.
`ifndef MOS6502_OPERAND_MODE_PARSER_ASSERT_SVH
`define MOS6502_OPERAND_MODE_PARSER_ASSERT_SVH
`ifndef SYNTH
`define M6502OP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define M6502OP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define M6502OP_ASSERT_IMP(lbl, ante, cons, msg)
`define M6502OP_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ----- rtl/m6502op_pkg.sv -----
// Types and constants shared by the 6502 operand mode parser modules.
package m6502op_pkg;

  typedef enum logic [3:0] {
    MODE_NONE = 4'd0,
    MODE_IMM  = 4'd1,
    MODE_ZP   = 4'd2,
    MODE_ZPX  = 4'd3,
    MODE_ZPY  = 4'd4,
    MODE_ABS  = 4'd5,
    MODE_ABSX = 4'd6,
    MODE_ABSY = 4'd7,
    MODE_INDX = 4'd8,
    MODE_INDY = 4'd9,
    MODE_ERR  = 4'd10
  } mode_t;

  typedef enum logic [3:0] {
    PH_NAME      = 4'd0,
    PH_SPACE     = 4'd1,
    PH_IMM_BYTE  = 4'd2,
    PH_IND_BYTE  = 4'd3,
    PH_IND_C0    = 4'd4,
    PH_IND_CM    = 4'd5,
    PH_IND_CMX   = 4'd6,
    PH_IND_PA    = 4'd7,
    PH_IND_PAC   = 4'd8,
    PH_ZP_BYTE   = 4'd9,
    PH_AFTER_ZP  = 4'd10,
    PH_ZP_INDEX  = 4'd11,
    PH_ABS_BYTE  = 4'd12,
    PH_AFTER_ABS = 4'd13,
    PH_ABS_INDEX = 4'd14
  } phase_t;

  typedef enum logic [1:0] {
    DIG_START  = 2'd0,
    DIG_DOLLAR = 2'd1,
    DIG_ONE    = 2'd2
  } digit_t;

  typedef struct packed {
    phase_t      phase;
    logic [15:0] accum;
    digit_t      digits;
    mode_t       mode;
    logic        settled;
  } parse_state_t;

  typedef struct packed {
    mode_t       mode;
    logic [15:0] value;
  } result_t;

  localparam parse_state_t ST_RESET = '{
    phase:   PH_NAME,
    accum:   16'h0000,
    digits:  DIG_START,
    mode:    MODE_NONE,
    settled: 1'b0
  };

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_X      = 8'h58;
  localparam logic [7:0] CH_Y      = 8'h59;

endpackage

// ----- rtl/m6502op_step.sv -----
// Next-state and result logic for one character of the operand parser.
module m6502op_step (
  input  m6502op_pkg::parse_state_t st,
  input  logic [7:0]                char_in,
  input  logic                      is_last,
  output m6502op_pkg::parse_state_t st_next,
  output m6502op_pkg::result_t      res
);

  function automatic logic [7:0] upcase(input logic [7:0] c);
    upcase = (c >= 8'h61 && c <= 8'h7A) ? c - 8'd32 : c;
  endfunction

  // bit 4 flags a valid hex digit
  function automatic logic [4:0] hex_nibble(input logic [7:0] c);
    logic [7:0] d;
    d = 8'h00;
    if (c >= 8'h30 && c <= 8'h39) begin
      d = c - 8'h30;
      hex_nibble = {1'b1, d[3:0]};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      d = c - 8'h37;
      hex_nibble = {1'b1, d[3:0]};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      d = c - 8'h57;
      hex_nibble = {1'b1, d[3:0]};
    end else begin
      hex_nibble = 5'b0_0000;
    end
  endfunction

  function automatic m6502op_pkg::parse_state_t settle(input m6502op_pkg::parse_state_t s,
                                                       input m6502op_pkg::mode_t m);
    m6502op_pkg::parse_state_t r;
    r = s;
    r.mode = m;
    r.settled = 1'b1;
    settle = r;
  endfunction

  function automatic m6502op_pkg::parse_state_t byte_step(
      input m6502op_pkg::parse_state_t s, input logic [7:0] c,
      input m6502op_pkg::phase_t nxt, input logic imm);
    m6502op_pkg::parse_state_t r;
    logic [4:0] nib;
    r = s;
    nib = hex_nibble(c);
    if (s.digits == m6502op_pkg::DIG_START && c == m6502op_pkg::CH_DOLLAR) begin
      r.digits = m6502op_pkg::DIG_DOLLAR;
    end else if (!nib[4]) begin
      r = settle(s, m6502op_pkg::MODE_ERR);
    end else begin
      r.accum = {s.accum[11:0], nib[3:0]};
      if (s.digits == m6502op_pkg::DIG_ONE) begin
        r.digits = m6502op_pkg::DIG_START;
        if (imm) begin
          r = settle(r, m6502op_pkg::MODE_IMM);
        end else begin
          r.phase = nxt;
        end
      end else begin
        r.digits = m6502op_pkg::DIG_ONE;
      end
    end
    byte_step = r;
  endfunction

  function automatic m6502op_pkg::parse_state_t index_letter(
      input m6502op_pkg::parse_state_t s, input logic [7:0] c,
      input m6502op_pkg::mode_t mx, input m6502op_pkg::mode_t my);
    logic [7:0] u;
    u = upcase(c);
    if (u == m6502op_pkg::CH_X) begin
      index_letter = settle(s, mx);
    end else if (u == m6502op_pkg::CH_Y) begin
      index_letter = settle(s, my);
    end else begin
      index_letter = settle(s, m6502op_pkg::MODE_ERR);
    end
  endfunction

  function automatic m6502op_pkg::parse_state_t feed(input m6502op_pkg::parse_state_t s,
                                                     input logic [7:0] c);
    m6502op_pkg::parse_state_t r;
    r = s;
    if (!s.settled) begin
      case (s.phase)
        m6502op_pkg::PH_NAME: begin
          if (c == m6502op_pkg::CH_SPACE) r.phase = m6502op_pkg::PH_SPACE;
        end
        m6502op_pkg::PH_SPACE: begin
          if (c == m6502op_pkg::CH_SPACE) begin
            r = s;
          end else if (c == m6502op_pkg::CH_NUL) begin
            r = settle(s, m6502op_pkg::MODE_NONE);
          end else if (c == m6502op_pkg::CH_HASH) begin
            r.phase = m6502op_pkg::PH_IMM_BYTE;
          end else if (c == m6502op_pkg::CH_LPAREN) begin
            r.phase = m6502op_pkg::PH_IND_BYTE;
          end else begin
            r.phase = m6502op_pkg::PH_ZP_BYTE;
            r = byte_step(r, c, m6502op_pkg::PH_AFTER_ZP, 1'b0);
          end
        end
        m6502op_pkg::PH_IMM_BYTE: r = byte_step(s, c, m6502op_pkg::PH_IMM_BYTE, 1'b1);
        m6502op_pkg::PH_IND_BYTE: r = byte_step(s, c, m6502op_pkg::PH_IND_C0, 1'b0);
        m6502op_pkg::PH_IND_C0: begin
          if (c == m6502op_pkg::CH_COMMA) begin
            r.phase = m6502op_pkg::PH_IND_CM;
          end else if (c == m6502op_pkg::CH_RPAREN) begin
            r.phase = m6502op_pkg::PH_IND_PA;
          end else begin
            r = settle(s, m6502op_pkg::MODE_ERR);
          end
        end
        m6502op_pkg::PH_IND_CM: begin
          if (upcase(c) == m6502op_pkg::CH_X) begin
            r.phase = m6502op_pkg::PH_IND_CMX;
          end else begin
            r = settle(s, m6502op_pkg::MODE_ERR);
          end
        end
        m6502op_pkg::PH_IND_CMX: begin
          r = settle(s, (c == m6502op_pkg::CH_RPAREN) ? m6502op_pkg::MODE_INDX
                                                       : m6502op_pkg::MODE_ERR);
        end
        m6502op_pkg::PH_IND_PA: begin
          if (c == m6502op_pkg::CH_COMMA) begin
            r.phase = m6502op_pkg::PH_IND_PAC;
          end else begin
            r = settle(s, m6502op_pkg::MODE_ERR);
          end
        end
        m6502op_pkg::PH_IND_PAC: begin
          r = settle(s, (upcase(c) == m6502op_pkg::CH_Y) ? m6502op_pkg::MODE_INDY
                                                          : m6502op_pkg::MODE_ERR);
        end
        m6502op_pkg::PH_ZP_BYTE: r = byte_step(s, c, m6502op_pkg::PH_AFTER_ZP, 1'b0);
        m6502op_pkg::PH_AFTER_ZP: begin
          if (c == m6502op_pkg::CH_NUL) begin
            r = settle(s, m6502op_pkg::MODE_ZP);
          end else if (c == m6502op_pkg::CH_COMMA) begin
            r.phase = m6502op_pkg::PH_ZP_INDEX;
          end else begin
            r.phase = m6502op_pkg::PH_ABS_BYTE;
            r = byte_step(r, c, m6502op_pkg::PH_AFTER_ABS, 1'b0);
          end
        end
        m6502op_pkg::PH_ZP_INDEX:
          r = index_letter(s, c, m6502op_pkg::MODE_ZPX, m6502op_pkg::MODE_ZPY);
        m6502op_pkg::PH_ABS_BYTE: r = byte_step(s, c, m6502op_pkg::PH_AFTER_ABS, 1'b0);
        m6502op_pkg::PH_AFTER_ABS: begin
          if (c == m6502op_pkg::CH_NUL) begin
            r = settle(s, m6502op_pkg::MODE_ABS);
          end else if (c == m6502op_pkg::CH_COMMA) begin
            r.phase = m6502op_pkg::PH_ABS_INDEX;
          end else begin
            r = settle(s, m6502op_pkg::MODE_ERR);
          end
        end
        m6502op_pkg::PH_ABS_INDEX:
          r = index_letter(s, c, m6502op_pkg::MODE_ABSX, m6502op_pkg::MODE_ABSY);
        default: r = settle(s, m6502op_pkg::MODE_ERR);
      endcase
    end
    feed = r;
  endfunction

  m6502op_pkg::parse_state_t after_char;
  m6502op_pkg::parse_state_t at_end;

  always_comb begin
    after_char = feed(st, char_in);
    at_end = after_char;
    if (!after_char.settled) begin
      if (after_char.phase == m6502op_pkg::PH_NAME) begin
        at_end = settle(after_char, m6502op_pkg::MODE_NONE);
      end else begin
        at_end = feed(after_char, m6502op_pkg::CH_NUL);
      end
    end
    if (!at_end.settled) begin
      at_end = settle(at_end, m6502op_pkg::MODE_ERR);
    end
    res.mode = at_end.mode;
    res.value = (at_end.mode == m6502op_pkg::MODE_NONE || at_end.mode == m6502op_pkg::MODE_ERR)
                ? 16'h0000 : at_end.accum;
    st_next = is_last ? m6502op_pkg::ST_RESET : after_char;
  end

endmodule

// ----- rtl/mos6502_operand_mode_parser.sv -----
// Top level of the 6502 operand addressing mode parser.
// Feed one source line a character per cycle on char_in, with is_last on the final
// character; a full character rate (one per cycle) is sustained while char_ready is high.
// Each character is registered, then one pass of parse logic updates the line state, so
// the result (addr_mode and operand_value) is loaded into the result register when the
// registered last character advances. char_ready drops only when a finished result still
// sits in the result register unclaimed and the registered character would make another.
// The parser starts the next line with the character after the last one.
`include "mos6502_operand_mode_parser_assert.svh"
module mos6502_operand_mode_parser (
  input  logic        clk,
  input  logic        rst,
  input  logic [7:0]  char_in,
  input  logic        is_last,
  input  logic        char_valid,
  output logic        char_ready,
  output logic [3:0]  addr_mode,
  output logic [15:0] operand_value,
  output logic        result_valid,
  input  logic        result_ready
);

  logic                      s1_valid;
  logic [7:0]                s1_char;
  logic                      s1_last;
  m6502op_pkg::parse_state_t st;
  m6502op_pkg::parse_state_t st_next;
  m6502op_pkg::result_t      res;
  logic                      advance;

  m6502op_step u_step (
    .st      (st),
    .char_in (s1_char),
    .is_last (s1_last),
    .st_next (st_next),
    .res     (res)
  );

  assign advance    = s1_valid && (!s1_last || !result_valid || result_ready);
  assign char_ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      st           <= m6502op_pkg::ST_RESET;
      result_valid <= 1'b0;
    end else begin
      if (char_ready) s1_valid <= char_valid;
      if (advance) st <= st_next;
      if (advance && s1_last) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (char_valid && char_ready) begin
      s1_char <= char_in;
      s1_last <= is_last;
    end
    if (advance && s1_last) begin
      addr_mode     <= res.mode;
      operand_value <= res.value;
    end
  end

  `M6502OP_ASSERT_IMP(a_zero_value, result_valid && (addr_mode == m6502op_pkg::MODE_NONE || addr_mode == m6502op_pkg::MODE_ERR), operand_value == 16'h0000, "value not zero for none or error")
  `M6502OP_ASSERT_IMP(a_no_overwrite, advance && s1_last, !result_valid || result_ready, "result overwritten before taken")
  `M6502OP_ASSERT_NEXT(a_line_restart, advance && s1_last, st == m6502op_pkg::ST_RESET, "parse state not cleared after line")
  `M6502OP_ASSERT_NEXT(a_request_held, char_valid && char_ready, s1_valid, "accepted request lost")

endmodule
